// File: rtl/tcle_pkg.sv
// Shared types, codes and helper functions of the connection engine.
package tcle_pkg;

   localparam int unsigned PayloadLenMax = 65535;

   // Input operation codes
   localparam logic [2:0] OP_SEND  = 3'd0;
   localparam logic [2:0] OP_OPEN  = 3'd1;
   localparam logic [2:0] OP_CLOSE = 3'd2;
   localparam logic [2:0] OP_SEG   = 3'd3;
   localparam logic [2:0] OP_TICK  = 3'd4;

   // Register indexes
   localparam logic REG_ISN = 1'b0;
   localparam logic REG_RTO = 1'b1;

   // Delivery status codes
   localparam logic [1:0] STAT_OPEN    = 2'd1;
   localparam logic [1:0] STAT_CLOSING = 2'd2;

   // Result kinds
   localparam logic KIND_SEG = 1'b0;
   localparam logic KIND_DLV = 1'b1;

   typedef enum logic [2:0] {
      CMD_NONE, CMD_SRV_SEND, CMD_SEND, CMD_OPEN, CMD_CLOSE, CMD_SEG, CMD_TICK
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_CLOSED, ST_ESTAB, ST_SYN_SENT, ST_SYN_RCVD,
      ST_FIN_WAIT, ST_CLOSE_WAIT, ST_TIME_WAIT, ST_LAST_ACK
   } conn_state_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  sp;
      logic [15:0]  dp;
      logic [15:0]  len;
      logic [15:0]  handle;
      logic         hp;
      logic         fin;
      logic [31:0]  sq;
      logic [31:0]  ak;
   } cmd_type;

   typedef struct packed {
      logic [15:0] sp;
      logic [15:0] dp;
      logic [31:0] seq;
      logic [31:0] ack;
      logic        syn;
      logic        ackf;
      logic        fin;
      logic [15:0] plen;
      logic [15:0] ph;
   } seg_type;

   typedef struct packed {
      logic        kind;
      seg_type     seg;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] isn;
      logic [15:0] rto;
   } csr_type;

   // Queue fill levels and the item pop signal seen by the top level
   typedef struct packed {
      logic [1:0] cmd_count;
      logic [2:0] rsp_count;
      logic       pop;
   } status_type;

   function automatic seg_type mk_seg(input logic [15:0] sp, input logic [15:0] dp,
                                      input logic [31:0] seq, input logic [31:0] ack,
                                      input logic ackf);
      seg_type s;
      s      = '0;
      s.sp   = sp;
      s.dp   = dp;
      s.seq  = seq;
      s.ack  = ack;
      s.ackf = ackf;
      return s;
   endfunction

   function automatic rsp_type seg_rsp(input seg_type s);
      rsp_type r;
      r      = '0;
      r.kind = KIND_SEG;
      r.seg  = s;
      return r;
   endfunction

   function automatic rsp_type dlv_rsp(input logic [15:0] sp, input logic [15:0] dp,
                                       input logic [15:0] len, input logic [15:0] h,
                                       input logic [1:0] st);
      rsp_type r;
      r             = '0;
      r.kind        = KIND_DLV;
      r.seg.sp      = sp;
      r.seg.dp      = dp;
      r.seg.plen    = len;
      r.seg.ph      = h;
      r.status      = st;
      return r;
   endfunction

endpackage

// File: rtl/tcle_front.sv
// Front end: accepts items, classifies them and queues them for the engine.
module tcle_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_operation,
   input  logic             req_server_side,
   input  logic [15:0]      req_source_port,
   input  logic [15:0]      req_dest_port,
   input  logic [15:0]      req_payload_length,
   input  logic [15:0]      req_payload_handle,
   input  logic             req_has_payload,
   input  logic             req_fin_flag,
   input  logic [31:0]      req_seq_number,
   input  logic [31:0]      req_ack_number,
   output logic             cmd_valid,
   output tcle_pkg::cmd_type cmd,
   input  logic             cmd_pop,
   output logic [1:0]       cmd_count
);
   import tcle_pkg::*;

   cmd_type    q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic       push;

   // Classify the operation; server open/close and unknown codes vanish here
   always_comb begin
      cls        = '0;
      cls.sp     = req_source_port;
      cls.dp     = req_dest_port;
      cls.len    = req_payload_length;
      cls.handle = req_payload_handle;
      cls.hp     = req_has_payload;
      cls.fin    = req_fin_flag;
      cls.sq     = req_seq_number;
      cls.ak     = req_ack_number;
      case (req_operation)
         OP_SEND:  cls.kind = req_server_side ? CMD_SRV_SEND : CMD_SEND;
         OP_OPEN:  cls.kind = req_server_side ? CMD_NONE : CMD_OPEN;
         OP_CLOSE: cls.kind = req_server_side ? CMD_NONE : CMD_CLOSE;
         OP_SEG:   cls.kind = CMD_SEG;
         OP_TICK:  cls.kind = CMD_TICK;
         default:  cls.kind = CMD_NONE;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall && (cls.kind != CMD_NONE);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];
   assign cmd_count = cnt_ff;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = cmd_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule

// File: rtl/tcle_back.sv
// Back end: connection state, sequence numbers, timer and result generation.
module tcle_back (
   input  logic               clock,
   input  logic               reset,
   input  tcle_pkg::csr_type  csr,
   input  logic               cmd_valid,
   input  tcle_pkg::cmd_type  cmd,
   input  logic               room,
   output logic               cmd_pop,
   output logic [1:0]         push_n,
   output tcle_pkg::rsp_type  r0,
   output tcle_pkg::rsp_type  r1
);
   import tcle_pkg::*;

   conn_state_type conn_ff, conn_in;
   logic [31:0] seq_ff, seq_in, rack_ff, rack_in;
   logic        await_ff, await_in, held_v_ff, held_v_in;
   logic [15:0] held_len_ff, held_len_in, held_h_ff, held_h_in;
   seg_type     last_ff, last_in;
   logic [16:0] tcnt_ff, tcnt_in;
   logic [1:0]  tmode_ff, tmode_in;
   logic [1:0]  nres;
   logic [31:0] diff;
   seg_type     s;
   rsp_type     a, b;

   assign cmd_pop = cmd_valid && room;
   assign diff    = cmd.ak - seq_ff;

   // Next state and results of the item at the queue head
   always_comb begin
      conn_in     = conn_ff;
      seq_in      = seq_ff;
      rack_in     = rack_ff;
      await_in    = await_ff;
      held_v_in   = held_v_ff;
      held_len_in = held_len_ff;
      held_h_in   = held_h_ff;
      last_in     = last_ff;
      tcnt_in     = tcnt_ff;
      tmode_in    = tmode_ff;
      nres        = 2'd0;
      a           = '0;
      b           = '0;
      s           = '0;
      case (cmd.kind)
         CMD_SRV_SEND, CMD_SEND, CMD_OPEN, CMD_CLOSE: begin
            if (cmd.kind == CMD_OPEN && conn_ff == ST_CLOSED) begin
               // active open: SYN, payload held for later
               s         = mk_seg(cmd.sp, cmd.dp, seq_ff, 32'd0, 1'b0);
               s.syn     = 1'b1;
               a         = seg_rsp(s);
               nres      = 2'd1;
               last_in   = s;
               seq_in    = seq_ff + 32'd1;
               conn_in   = ST_SYN_SENT;
               held_v_in = 1'b1;
               held_len_in = cmd.len;
               held_h_in = cmd.handle;
               tmode_in  = tmode_ff | 2'b01;
               tcnt_in   = {1'b0, csr.rto};
            end else if (cmd.kind == CMD_SRV_SEND || cmd.kind == CMD_CLOSE ||
                         conn_ff == ST_ESTAB) begin
               // data segment
               if (cmd.kind == CMD_SRV_SEND) begin
                  s = mk_seg(cmd.dp, cmd.sp, seq_ff, rack_ff, 1'b1);
               end else begin
                  s = mk_seg(cmd.sp, cmd.dp, seq_ff, rack_ff, 1'b1);
               end
               s.fin    = (cmd.kind == CMD_CLOSE);
               s.plen   = cmd.len;
               s.ph     = cmd.handle;
               a        = seg_rsp(s);
               nres     = 2'd1;
               last_in  = s;
               seq_in   = seq_ff + {16'd0, cmd.len};
               await_in = 1'b1;
               tmode_in = tmode_ff | 2'b01;
               tcnt_in  = {1'b0, csr.rto};
               if (cmd.kind == CMD_CLOSE) begin
                  conn_in = ST_FIN_WAIT;
               end
            end
         end
         CMD_TICK: begin
            if (tmode_ff[0]) begin
               if (tcnt_ff <= 17'd1) begin
                  if (tmode_ff[1]) begin
                     conn_in   = ST_CLOSED;
                     seq_in    = csr.isn;
                     rack_in   = '1;
                     await_in  = 1'b0;
                     held_v_in = 1'b0;
                     tcnt_in   = '0;
                     tmode_in  = 2'b00;
                  end else begin
                     a        = seg_rsp(last_ff);
                     nres     = 2'd1;
                     tmode_in = tmode_ff | 2'b01;
                     tcnt_in  = {1'b0, csr.rto};
                  end
               end else begin
                  tcnt_in = tcnt_ff - 17'd1;
               end
            end
         end
         CMD_SEG: begin
            if (conn_ff == ST_CLOSED) begin
               // passive open: SYN+ACK
               rack_in  = cmd.sq + 32'd1;
               s        = mk_seg(cmd.dp, cmd.sp, seq_ff, rack_in, 1'b1);
               s.syn    = 1'b1;
               a        = seg_rsp(s);
               nres     = 2'd1;
               last_in  = s;
               tmode_in = tmode_ff | 2'b01;
               tcnt_in  = {1'b0, csr.rto};
               seq_in   = seq_ff + 32'd1;
               conn_in  = ST_SYN_RCVD;
               await_in = 1'b1;
            end else if (conn_ff == ST_TIME_WAIT) begin
               if (cmd.fin) begin
                  a        = seg_rsp(last_ff);
                  nres     = 2'd1;
                  tmode_in = 2'b11;
                  tcnt_in  = {csr.rto, 1'b0};
               end
            end else if (diff[31]) begin
               // stale ack: resend
               a        = seg_rsp(last_ff);
               nres     = 2'd1;
               tmode_in = tmode_ff | 2'b01;
               tcnt_in  = {1'b0, csr.rto};
            end else if (diff == 32'd0) begin
               tmode_in = tmode_ff & 2'b10;
               if (await_ff && !cmd.hp) begin
                  await_in = 1'b0;
                  case (conn_ff)
                     ST_SYN_RCVD: conn_in = ST_ESTAB;
                     ST_CLOSE_WAIT: begin
                        s        = mk_seg(cmd.dp, cmd.sp, seq_ff, rack_ff, 1'b1);
                        s.fin    = 1'b1;
                        a        = seg_rsp(s);
                        nres     = 2'd1;
                        last_in  = s;
                        conn_in  = ST_LAST_ACK;
                        await_in = 1'b1;
                        tmode_in = tmode_ff | 2'b01;
                        tcnt_in  = {1'b0, csr.rto};
                        seq_in   = seq_ff + 32'd1;
                     end
                     ST_LAST_ACK: begin
                        conn_in   = ST_CLOSED;
                        seq_in    = csr.isn;
                        rack_in   = '1;
                        held_v_in = 1'b0;
                        tcnt_in   = '0;
                        tmode_in  = 2'b00;
                     end
                     default: ;
                  endcase
               end else begin
                  case (conn_ff)
                     ST_SYN_SENT: begin
                        rack_in = cmd.sq + 32'd1;
                        s       = mk_seg(cmd.dp, cmd.sp, seq_ff, rack_in, 1'b1);
                        a       = seg_rsp(s);
                        nres    = 2'd1;
                        last_in = s;
                        conn_in = ST_ESTAB;
                        if (held_v_ff) begin
                           s.plen   = held_len_ff;
                           s.ph     = held_h_ff;
                           b        = seg_rsp(s);
                           nres     = 2'd2;
                           last_in  = s;
                           tmode_in = tmode_ff | 2'b01;
                           tcnt_in  = {1'b0, csr.rto};
                           seq_in   = seq_ff + {16'd0, held_len_ff};
                           await_in = 1'b1;
                        end
                     end
                     ST_ESTAB: begin
                        if (!cmd.hp) begin
                           if (cmd.fin) begin
                              // ACK then FIN+ACK, ports as received
                              rack_in  = rack_ff + 32'd1;
                              s        = mk_seg(cmd.sp, cmd.dp, seq_ff, rack_in, 1'b1);
                              a        = seg_rsp(s);
                              s.fin    = 1'b1;
                              b        = seg_rsp(s);
                              nres     = 2'd2;
                              last_in  = s;
                              tmode_in = tmode_ff | 2'b01;
                              tcnt_in  = {1'b0, csr.rto};
                              conn_in  = ST_LAST_ACK;
                              await_in = 1'b1;
                           end
                        end else begin
                           a       = dlv_rsp(cmd.sp, cmd.dp, cmd.len, cmd.handle,
                                             STAT_OPEN);
                           rack_in = rack_ff + {16'd0, cmd.len};
                           s       = mk_seg(cmd.dp, cmd.sp, seq_ff, rack_in, 1'b1);
                           b       = seg_rsp(s);
                           nres    = 2'd2;
                           last_in = s;
                           if (cmd.fin) begin
                              conn_in = ST_CLOSE_WAIT;
                           end
                        end
                     end
                     ST_FIN_WAIT: begin
                        if (!cmd.fin) begin
                           if (cmd.hp) begin
                              a       = dlv_rsp(cmd.sp, cmd.dp, cmd.len, cmd.handle,
                                                STAT_CLOSING);
                              rack_in = rack_ff + {16'd0, cmd.len};
                              s       = mk_seg(cmd.dp, cmd.sp, seq_ff, rack_in, 1'b1);
                              b       = seg_rsp(s);
                              nres    = 2'd2;
                           end else begin
                              s    = mk_seg(cmd.dp, cmd.sp, seq_ff, rack_ff, 1'b1);
                              a    = seg_rsp(s);
                              nres = 2'd1;
                           end
                           last_in = s;
                        end else begin
                           rack_in  = rack_ff + 32'd1;
                           s        = mk_seg(cmd.dp, cmd.sp, seq_ff, rack_in, 1'b1);
                           a        = seg_rsp(s);
                           nres     = 2'd1;
                           last_in  = s;
                           conn_in  = ST_TIME_WAIT;
                           tmode_in = 2'b11;
                           tcnt_in  = {csr.rto, 1'b0};
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         default: ;
      endcase
      a.last = (nres == 2'd1);
      b.last = 1'b1;
   end

   assign r0     = a;
   assign r1     = b;
   assign push_n = cmd_pop ? nres : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_ff     <= ST_CLOSED;
         seq_ff      <= 32'd100;
         rack_ff     <= '0;
         await_ff    <= 1'b0;
         held_v_ff   <= 1'b0;
         held_len_ff <= '0;
         held_h_ff   <= '0;
         tcnt_ff     <= '0;
         tmode_ff    <= 2'b00;
      end else if (cmd_pop) begin
         conn_ff     <= conn_in;
         seq_ff      <= seq_in;
         rack_ff     <= rack_in;
         await_ff    <= await_in;
         held_v_ff   <= held_v_in;
         held_len_ff <= held_len_in;
         held_h_ff   <= held_h_in;
         tcnt_ff     <= tcnt_in;
         tmode_ff    <= tmode_in;
      end
   end

   // Last sent segment, all header and payload fields, kept for resends
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         last_ff <= last_in;
      end
   end

endmodule

// File: rtl/tcle_rsp_queue.sv
// Result queue: takes up to two results a cycle, hands out one unless rsp_stall is high.
module tcle_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_n,
   input  tcle_pkg::rsp_type d0,
   input  tcle_pkg::rsp_type d1,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcle_pkg::rsp_type rsp,
   output logic [2:0]        count
);
   import tcle_pkg::*;

   rsp_type    q_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign rsp_valid = (cnt_ff != 3'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp       = q_ff[rp_ff];
   assign room      = (cnt_ff <= 3'd2);
   assign count     = cnt_ff;

   always_comb begin
      wp_in  = wp_ff + push_n;
      rp_in  = rp_ff + {1'b0, pop};
      cnt_in = cnt_ff + {1'b0, push_n} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_ff[wp_ff] <= d0;
      end
      if (push_n == 2'd2) begin
         q_ff[wp_ff + 2'd1] <= d1;
      end
   end

endmodule

// File: rtl/tcp_lite_connection_engine.sv
// Top level of the single-connection TCP engine.
// A two-entry item queue feeds the connection engine, which handles one item per
// clock while its four-entry result queue has room for two results; results leave
// one per cycle while rsp_stall is low, and new items are taken while earlier
// results still wait in the queue. The first result of an item passes through the
// item queue and the result queue registers before it can be taken. Server-side
// open and close, and unknown operation codes, are dropped at the input.
// Registers must be written by the user only while idle; the block does not check.
module tcp_lite_connection_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic        req_server_side,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [15:0] req_payload_length,
   input  logic [15:0] req_payload_handle,
   input  logic        req_has_payload,
   input  logic        req_fin_flag,
   input  logic [31:0] req_seq_number,
   input  logic [31:0] req_ack_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_out_source_port,
   output logic [15:0] rsp_out_dest_port,
   output logic [31:0] rsp_out_seq,
   output logic [31:0] rsp_out_ack,
   output logic        rsp_out_syn,
   output logic        rsp_out_ack_flag,
   output logic        rsp_out_fin,
   output logic [15:0] rsp_out_payload_length,
   output logic [15:0] rsp_out_payload_handle,
   output logic [1:0]  rsp_app_status,
   output logic        rsp_last_result
);
   import tcle_pkg::*;

   csr_type    csr_ff, csr_in;
   cmd_type    cmd;
   logic       cmd_valid, room;
   logic [1:0] push_n;
   rsp_type    r0, r1, rsp;
   status_type stat;

   // Configuration registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_ISN: csr_in.isn = csr_write_data;
            REG_RTO: csr_in.rto = csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.isn <= 32'd100;
         csr_ff.rto <= 16'd1;
      end else begin
         csr_ff <= csr_in;
      end
   end

   tcle_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_server_side,
      .req_source_port, .req_dest_port, .req_payload_length, .req_payload_handle,
      .req_has_payload, .req_fin_flag, .req_seq_number, .req_ack_number,
      .cmd_valid, .cmd, .cmd_pop(stat.pop), .cmd_count(stat.cmd_count)
   );

   tcle_back u_back (
      .clock, .reset, .csr(csr_ff), .cmd_valid, .cmd, .room,
      .cmd_pop(stat.pop), .push_n, .r0, .r1
   );

   tcle_rsp_queue u_rsp (
      .clock, .reset, .push_n, .d0(r0), .d1(r1), .room, .rsp_valid, .rsp_stall,
      .rsp, .count(stat.rsp_count)
   );

   assign rsp_result_kind        = rsp.kind;
   assign rsp_out_source_port    = rsp.seg.sp;
   assign rsp_out_dest_port      = rsp.seg.dp;
   assign rsp_out_seq            = rsp.seg.seq;
   assign rsp_out_ack            = rsp.seg.ack;
   assign rsp_out_syn            = rsp.seg.syn;
   assign rsp_out_ack_flag       = rsp.seg.ackf;
   assign rsp_out_fin            = rsp.seg.fin;
   assign rsp_out_payload_length = rsp.seg.plen;
   assign rsp_out_payload_handle = rsp.seg.ph;
   assign rsp_app_status         = rsp.status;
   assign rsp_last_result        = rsp.last;

`ifndef SYNTHESIS
   // engine never runs an item without room for two results
   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      stat.pop |-> stat.rsp_count <= 3'd2) else $error("pop without room");
   // result queue never overfills
   a_rsp_bound: assert property (@(posedge clock) disable iff (reset)
      stat.rsp_count <= 3'd4) else $error("result queue overflow");
   // item queue never overfills
   a_cmd_bound: assert property (@(posedge clock) disable iff (reset)
      stat.cmd_count <= 2'd2) else $error("item queue overflow");
   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid) else $error("result after reset");
`endif

endmodule
